>>> design/ps2_mouse_packet_decoder_macros.svh
// ----------------------------------------------------------------------------
// PS/2 mouse packet decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_PACKET_DECODER_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_MACROS_SVH

// Same-cycle implication.
`define PS2MD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PS2MD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/ps2md_pkg.sv
// ----------------------------------------------------------------------------
// ps2md_pkg
// Types and constants shared by the PS/2 mouse packet decoder.
// ----------------------------------------------------------------------------
package ps2md_pkg;

  localparam int unsigned BYTE_W = 8;

  // Header bit positions
  localparam int unsigned HDR_SYNC_BIT = 3;
  localparam int unsigned HDR_XSIGN_BIT = 4;
  localparam int unsigned HDR_YSIGN_BIT = 5;

  // Event kinds
  localparam logic [2:0] EV_IGNORE = 3'd0;
  localparam logic [2:0] EV_DOWN   = 3'd1;
  localparam logic [2:0] EV_UP     = 3'd2;
  localparam logic [2:0] EV_MOVE   = 3'd3;
  localparam logic [2:0] EV_SCROLL = 3'd4;

  // One complete packet as handed from the front to the back
  typedef struct packed {
    logic [BYTE_W-1:0] header;
    logic [BYTE_W-1:0] x_raw;
    logic [BYTE_W-1:0] y_raw;
    logic [BYTE_W-1:0] scroll_raw;
  } pkt_t;

endpackage

>>> design/ps2md_byte_if.sv
// ----------------------------------------------------------------------------
// ps2md_byte_if
// Valid/ready channel carrying one mouse byte per transaction.
// ----------------------------------------------------------------------------
interface ps2md_byte_if import ps2md_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

>>> design/ps2md_event_if.sv
// ----------------------------------------------------------------------------
// ps2md_event_if
// Valid/ready channel carrying one decoded mouse event per transaction.
// ----------------------------------------------------------------------------
interface ps2md_event_if ();
  logic              valid;
  logic              ready;
  logic [2:0]        event_kind;
  logic signed [8:0] delta_x;
  logic signed [8:0] delta_y;
  logic signed [7:0] scroll_y;
  logic [2:0]        button_mask;

  modport source (output valid, output event_kind, output delta_x, output delta_y,
                  output scroll_y, output button_mask, input ready);
  modport sink   (input valid, input event_kind, input delta_x, input delta_y,
                  input scroll_y, input button_mask, output ready);
endinterface

>>> design/ps2md_front.sv
// ----------------------------------------------------------------------------
// ps2md_front
// Byte framing: tracks the packet phase, collects header, X, Y and scroll
// bytes, and pushes a complete packet to the queue.
// ----------------------------------------------------------------------------
module ps2md_front import ps2md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  ps2md_byte_if.sink in_byte,
  output pkt_t push_pkt,
  output logic push,
  input  logic push_ready
);

  localparam logic [1:0] PH_HDR = 2'd0;
  localparam logic [1:0] PH_X   = 2'd1;
  localparam logic [1:0] PH_Y   = 2'd2;
  localparam logic [1:0] PH_SCR = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic              wheel_r;
  logic [BYTE_W-1:0] header_r, x_r, y_r;
  logic              completes;
  logic              accept;

  // Last byte of a packet needs queue space; other bytes never wait
  assign completes = (phase_r == PH_SCR) || ((phase_r == PH_Y) && !wheel_r);
  assign in_byte.ready = push_ready || !completes;
  assign accept = in_byte.valid && in_byte.ready;
  assign push = accept && completes;

  always_comb begin
    push_pkt.header = header_r;
    push_pkt.x_raw = x_r;
    push_pkt.y_raw = (phase_r == PH_Y) ? in_byte.data_byte : y_r;
    push_pkt.scroll_raw = (phase_r == PH_SCR && wheel_r) ? in_byte.data_byte
                                                         : {BYTE_W{1'b0}};
  end

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_HDR: begin
        if (in_byte.data_byte[HDR_SYNC_BIT]) phase_nxt = PH_X;
      end
      PH_X: phase_nxt = PH_Y;
      PH_Y: phase_nxt = wheel_r ? PH_SCR : PH_HDR;
      PH_SCR: phase_nxt = PH_HDR;
      default: phase_nxt = PH_HDR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      wheel_r <= 1'b0;
      header_r <= '0;
      x_r <= '0;
      y_r <= '0;
    end else begin
      if (cfg_we) wheel_r <= cfg_wdata;
      if (accept) begin
        phase_r <= phase_nxt;
        case (phase_r)
          PH_HDR: header_r <= in_byte.data_byte;
          PH_X: x_r <= in_byte.data_byte;
          PH_Y: y_r <= in_byte.data_byte;
          default: ;
        endcase
      end
    end
  end

endmodule

>>> design/ps2md_queue.sv
// ----------------------------------------------------------------------------
// ps2md_queue
// Two-entry packet queue between the framing front and the event back.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2md_queue import ps2md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  pkt_t push_pkt,
  input  logic push,
  output logic push_ready,
  output pkt_t head_pkt,
  output logic head_valid,
  input  logic pop
);

  pkt_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign head_valid = (cnt_r != 2'd0);
  assign head_pkt = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_pkt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_nxt;
    end
  end

  `PS2MD_ASSERT_NOW(a_no_overflow, push, cnt_r != 2'd2, "packet pushed into full queue")
  `PS2MD_ASSERT_NOW(a_no_underflow, pop, cnt_r != 2'd0, "packet popped from empty queue")
  `PS2MD_ASSERT_NOW(a_ptr_match, cnt_r == 2'd1 || cnt_r == 2'd0 || cnt_r == 2'd2,
                    (cnt_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "queue pointers and count disagree")

endmodule

>>> design/ps2md_back.sv
// ----------------------------------------------------------------------------
// ps2md_back
// Event builder: sign-extends the movement, classifies the button change
// against the previous packet and holds the result in an output register.
// ----------------------------------------------------------------------------
`include "ps2_mouse_packet_decoder_macros.svh"

module ps2md_back import ps2md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  pkt_t head_pkt,
  input  logic head_valid,
  output logic pop,
  ps2md_event_if.source out_event
);

  logic              valid_r;
  logic [2:0]        kind_r, kind_nxt;
  logic signed [8:0] dx_r, dx_nxt;
  logic signed [8:0] dy_r, dy_nxt;
  logic signed [7:0] sc_r;
  logic [2:0]        btn_r, btn_nxt;
  logic [2:0]        last_btn_r;
  logic [8:0]        y_ext;

  assign pop = head_valid && (!valid_r || out_event.ready);

  always_comb begin
    // a zero byte stays zero whatever its sign bit says
    dx_nxt = {head_pkt.header[HDR_XSIGN_BIT] && (head_pkt.x_raw != '0), head_pkt.x_raw};
    y_ext = {head_pkt.header[HDR_YSIGN_BIT] && (head_pkt.y_raw != '0), head_pkt.y_raw};
    dy_nxt = 9'sd0 - $signed(y_ext);
    btn_nxt = head_pkt.header[2:0];
    if (btn_nxt > last_btn_r) kind_nxt = EV_DOWN;
    else if (btn_nxt < last_btn_r) kind_nxt = EV_UP;
    else if (dx_nxt != 9'sd0 || dy_nxt != 9'sd0) kind_nxt = EV_MOVE;
    else if (head_pkt.scroll_raw != '0) kind_nxt = EV_SCROLL;
    else kind_nxt = EV_IGNORE;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= kind_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
      sc_r <= $signed(head_pkt.scroll_raw);
      btn_r <= btn_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_btn_r <= 3'd0;
    end else begin
      if (pop) begin
        valid_r <= 1'b1;
        last_btn_r <= btn_nxt;
      end else if (out_event.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_event.valid = valid_r;
  assign out_event.event_kind = kind_r;
  assign out_event.delta_x = dx_r;
  assign out_event.delta_y = dy_r;
  assign out_event.scroll_y = sc_r;
  assign out_event.button_mask = btn_r;

  `PS2MD_ASSERT_NOW(a_down_has_button, valid_r && kind_r == EV_DOWN, btn_r != 3'd0,
                    "button-down event with empty mask")
  `PS2MD_ASSERT_NOW(a_move_nonzero, valid_r && kind_r == EV_MOVE,
                    dx_r != 9'sd0 || dy_r != 9'sd0, "move event without movement")
  `PS2MD_ASSERT_NEXT(a_last_tracks_out, pop, last_btn_r == btn_r,
                     "previous mask not updated with issued event")

endmodule

>>> design/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Frames PS/2 mouse bytes into packets and issues one decoded event each.
// ----------------------------------------------------------------------------
// One mouse byte is taken per clock unless a final byte waits on a full
// queue. A packet is a header with bit 3 set, then X and Y, plus a scroll
// byte when cfg wheel mode is set (sampled when Y arrives). The final byte
// of a packet emits an event after passing a two-entry packet queue and the
// output register; the final byte waits only when that queue is full, other
// bytes never wait. Change wheel mode only between packets' results.
module ps2_mouse_packet_decoder import ps2md_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  ps2md_byte_if.sink in_byte,
  ps2md_event_if.source out_event
);

  pkt_t push_pkt, head_pkt;
  logic push, push_ready, head_valid, pop;

  ps2md_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_byte(in_byte),
    .push_pkt(push_pkt), .push(push), .push_ready(push_ready)
  );

  ps2md_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_pkt(push_pkt), .push(push), .push_ready(push_ready),
    .head_pkt(head_pkt), .head_valid(head_valid), .pop(pop)
  );

  ps2md_back u_back (
    .clk(clk), .rst_n(rst_n),
    .head_pkt(head_pkt), .head_valid(head_valid), .pop(pop),
    .out_event(out_event)
  );

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 mouse packet decoder. A queue-fed driver
// sends mouse bytes and wheel-mode writes, and a clocked predictor frames the
// packets in step with the decoder. A monitor checks each decoded event in
// order against the predicted ones. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb;
  import ps2md_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_BYTES   = 1950;
  localparam int unsigned MAX_SHOWN      = 10;

  typedef enum logic [1:0] {STIM_BYTE, STIM_WHEEL, STIM_DRAIN} stim_kind_e;

  typedef struct packed {
    stim_kind_e kind;
    logic [7:0] value;
  } stim_item_t;

  typedef enum logic [1:0] {PH_HEADER, PH_X, PH_Y, PH_SCROLL} pkt_phase_e;

  typedef struct packed {
    logic [2:0]        kind;
    logic signed [8:0] dx;
    logic signed [8:0] dy;
    logic signed [7:0] scroll;
    logic [2:0]        buttons;
  } mouse_event_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic cfg_we    = 1'b0;
  logic cfg_wdata = 1'b0;

  ps2md_byte_if  byte_ch ();
  ps2md_event_if event_ch ();

  ps2_mouse_packet_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_byte   (byte_ch),
    .out_event (event_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Packet framer state, kept in step with accepted bytes
  pkt_phase_e pkt_phase    = PH_HEADER;
  logic [7:0] hdr_q        = '0;
  logic [7:0] xbyte_q      = '0;
  logic [7:0] ybyte_q      = '0;
  logic [2:0] prev_buttons = '0;
  logic       wheel_mode   = 1'b0;

  stim_item_t   stim_q[$];
  mouse_event_t event_expect_q[$];

  int unsigned fault_cnt    = 0;
  int unsigned bytes_sent   = 0;
  int unsigned wheel_writes = 0;
  int unsigned kind_seen [0:4];

  function automatic logic [8:0] to_delta(input logic [7:0] raw, input logic neg);
    // a zero byte stays zero whatever the sign bit says
    return (raw != 8'h00 && neg) ? {1'b1, raw} : {1'b0, raw};
  endfunction

  function automatic bit close_packet(input logic [7:0] scroll_raw, output mouse_event_t ev);
    logic [2:0] btn;
    btn        = hdr_q[2:0];
    ev.dx      = to_delta(xbyte_q, hdr_q[HDR_XSIGN_BIT]);
    ev.dy      = -to_delta(ybyte_q, hdr_q[HDR_YSIGN_BIT]);
    ev.scroll  = wheel_mode ? scroll_raw : 8'h00;
    ev.buttons = btn;
    if (btn > prev_buttons) ev.kind = EV_DOWN;
    else if (btn < prev_buttons) ev.kind = EV_UP;
    else if (ev.dx != 0 || ev.dy != 0) ev.kind = EV_MOVE;
    else if (ev.scroll != 0) ev.kind = EV_SCROLL;
    else ev.kind = EV_IGNORE;
    prev_buttons = btn;
    pkt_phase    = PH_HEADER;
    return 1'b1;
  endfunction

  function automatic bit decode_mouse_byte(input logic [7:0] b, output mouse_event_t ev);
    ev = '0;
    case (pkt_phase)
      PH_HEADER: begin
        // latch every byte, but only a sync bit opens a packet
        hdr_q = b;
        if (b[HDR_SYNC_BIT]) pkt_phase = PH_X;
        return 1'b0;
      end
      PH_X: begin
        xbyte_q   = b;
        pkt_phase = PH_Y;
        return 1'b0;
      end
      PH_Y: begin
        ybyte_q = b;
        if (wheel_mode) begin
          pkt_phase = PH_SCROLL;
          return 1'b0;
        end
        return close_packet(8'h00, ev);
      end
      default: return close_packet(b, ev);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Driver
  // --------------------------------------------------------------------------
  int unsigned send_gap   = 0;
  int unsigned settle_cnt = 0;
  bit          send_burst = 1'b0;

  always @(posedge clk) begin
    logic         nxt_valid;
    logic         nxt_we;
    mouse_event_t ev;
    stim_item_t   item;
    if (!rst_n) begin
      byte_ch.valid <= 1'b0;
      cfg_we        <= 1'b0;
      send_gap      = 0;
      settle_cnt    = 0;
    end else begin
      nxt_valid = byte_ch.valid;
      nxt_we    = 1'b0;
      if (byte_ch.valid && byte_ch.ready) begin
        bytes_sent++;
        if (decode_mouse_byte(byte_ch.data_byte, ev)) event_expect_q.push_back(ev);
        nxt_valid = 1'b0;
      end
      if (event_expect_q.size() == 0 && !byte_ch.valid && !cfg_we) settle_cnt++;
      else settle_cnt = 0;
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (stim_q.size() > 0) begin
          item = stim_q[0];
          case (item.kind)
            STIM_BYTE: begin
              void'(stim_q.pop_front());
              nxt_valid = 1'b1;
              byte_ch.data_byte <= item.value;
              send_gap = send_burst ? 0 : $urandom_range(0, 3);
              if ($urandom_range(0, 63) == 0) send_burst = !send_burst;
            end
            STIM_WHEEL: begin
              // hold the write until the decoder has gone quiet
              if (settle_cnt >= SETTLE_CYCLES) begin
                void'(stim_q.pop_front());
                nxt_we = 1'b1;
                cfg_wdata <= item.value[0];
                wheel_mode = item.value[0];
                wheel_writes++;
              end
            end
            default: begin
              if (event_expect_q.size() == 0) void'(stim_q.pop_front());
            end
          endcase
        end
      end
      byte_ch.valid <= nxt_valid;
      cfg_we        <= nxt_we;
    end
  end

  // --------------------------------------------------------------------------
  // Monitor
  // --------------------------------------------------------------------------
  int unsigned recv_stall = 0;
  bit          recv_burst = 1'b0;

  always @(posedge clk) begin
    mouse_event_t want;
    mouse_event_t got;
    if (!rst_n) begin
      event_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (event_ch.valid && event_ch.ready) begin
        got.kind    = event_ch.event_kind;
        got.dx      = event_ch.delta_x;
        got.dy      = event_ch.delta_y;
        got.scroll  = event_ch.scroll_y;
        got.buttons = event_ch.button_mask;
        if (event_expect_q.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= MAX_SHOWN)
            $display("unexpected event: kind=%0d dx=%0d dy=%0d scroll=%0d buttons=%0d",
                     got.kind, got.dx, got.dy, got.scroll, got.buttons);
        end else begin
          want = event_expect_q.pop_front();
          if (want.kind <= EV_SCROLL) kind_seen[want.kind]++;
          if (got.kind !== want.kind || got.dx !== want.dx || got.dy !== want.dy ||
              got.scroll !== want.scroll || got.buttons !== want.buttons) begin
            fault_cnt++;
            if (fault_cnt <= MAX_SHOWN) begin
              $display("event mismatch at %0t", $realtime);
              $display("  expected kind=%0d dx=%0d dy=%0d scroll=%0d buttons=%0d",
                       want.kind, want.dx, want.dy, want.scroll, want.buttons);
              $display("  actual   kind=%0d dx=%0d dy=%0d scroll=%0d buttons=%0d",
                       got.kind, got.dx, got.dy, got.scroll, got.buttons);
            end
          end
        end
        recv_stall = recv_burst ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 31) == 0) recv_burst = !recv_burst;
      end
      if (recv_stall > 0) begin
        recv_stall--;
        event_ch.ready <= 1'b0;
      end else begin
        event_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (byte_ch.valid && byte_ch.ready) || (event_ch.valid && event_ch.ready) ||
        cfg_we) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d events still expected",
               quiet_cycles, event_expect_q.size());
      $display("FAIL ps2_mouse_packet_decoder");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  logic        gen_wheel   = 1'b0;
  logic [2:0]  gen_buttons = '0;
  int unsigned gen_bytes   = 0;

  task automatic push_byte(input logic [7:0] b);
    stim_q.push_back('{STIM_BYTE, b});
    gen_bytes++;
  endtask

  task automatic push_noise(input logic [7:0] b);
    stim_q.push_back('{STIM_BYTE, b & ~8'h08});
  endtask

  task automatic push_wheel(input logic v);
    stim_q.push_back('{STIM_WHEEL, {7'd0, v}});
    gen_wheel = v;
  endtask

  task automatic push_drain();
    stim_q.push_back('{STIM_DRAIN, 8'h00});
  endtask

  task automatic push_packet(input logic [7:0] hdr, input logic [7:0] x, input logic [7:0] y,
                             input logic [7:0] sc);
    push_byte(hdr);
    push_byte(x);
    push_byte(y);
    if (gen_wheel) push_byte(sc);
  endtask

  function automatic logic [7:0] pick_delta();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_header();
    if ($urandom_range(0, 1) == 0) gen_buttons = 3'($urandom_range(0, 7));
    return {4'($urandom_range(0, 15)), 1'b1, gen_buttons};
  endfunction

  initial begin
    int unsigned r;
    byte_ch.valid     = 1'b0;
    byte_ch.data_byte = '0;
    event_ch.ready    = 1'b0;

    // bytes without the sync bit are dropped while waiting for a header
    push_noise(8'h00);
    push_noise(8'hF7);
    push_packet(8'h08, 8'h00, 8'h00, 8'h00);
    push_packet(8'h38, 8'h00, 8'h00, 8'h00);
    push_packet(8'h1F, 8'h01, 8'h80, 8'h00);
    push_packet(8'h3F, 8'hFF, 8'hFF, 8'h00);
    push_drain();
    push_wheel(1'b1);
    push_packet(8'h0F, 8'h00, 8'h00, 8'h80);
    push_packet(8'h0E, 8'h00, 8'h00, 8'h7F);
    // drop wheel mode while the scroll byte is still owed
    push_byte(8'h08);
    push_byte(8'h10);
    push_byte(8'h20);
    push_wheel(1'b0);
    push_byte(8'hC3);
    // raise wheel mode between X and Y
    push_byte(8'h08);
    push_byte(8'h05);
    push_wheel(1'b1);
    push_byte(8'h00);
    push_byte(8'hFF);

    gen_bytes = 0;
    while (gen_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        push_packet(pick_header(), pick_delta(), pick_delta(), pick_delta());
      end else if (r < 88) begin
        repeat ($urandom_range(1, 3)) push_noise(8'($urandom_range(0, 255)));
      end else if (r < 93) begin
        // a header lands where a data byte belongs; zeros realign the framer
        push_byte(pick_header());
        if ($urandom_range(0, 1) == 0) push_byte(pick_delta());
        push_byte(pick_header());
        repeat (4) push_byte(8'h00);
      end else if (r < 96) begin
        push_byte(pick_header());
        push_byte(pick_delta());
        if (gen_wheel && $urandom_range(0, 1) == 0) begin
          push_byte(pick_delta());
          push_wheel(1'($urandom_range(0, 1)));
          push_byte(pick_delta());
        end else begin
          push_wheel(1'($urandom_range(0, 1)));
          push_byte(pick_delta());
          if (gen_wheel) push_byte(pick_delta());
        end
      end else if (r < 98) begin
        push_wheel(1'($urandom_range(0, 1)));
      end else begin
        push_drain();
      end
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (stim_q.size() != 0 || byte_ch.valid || event_expect_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (event_expect_q.size() != 0) begin
      $display("%0d expected events never arrived", event_expect_q.size());
      fault_cnt += event_expect_q.size();
    end
    $display("run: %0d bytes sent, %0d wheel-mode writes, %0d faults",
             bytes_sent, wheel_writes, fault_cnt);
    $display("events: %0d ignore, %0d down, %0d up, %0d move, %0d scroll",
             kind_seen[EV_IGNORE], kind_seen[EV_DOWN], kind_seen[EV_UP],
             kind_seen[EV_MOVE], kind_seen[EV_SCROLL]);
    if (fault_cnt == 0) $display("PASS ps2_mouse_packet_decoder");
    else $display("FAIL ps2_mouse_packet_decoder");
    $finish;
  end

endmodule
